// File: rtl/lrukv_pkg.sv
`default_nettype none

package lrukv_pkg;

  // default number of entries
  localparam int unsigned MAX_ENTRIES = 16;

  // field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  // configuration port
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // value returned by a get that misses
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // input item
  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } out_item_t;

  // update broadcast to every entry
  typedef struct packed {
    logic                    en;
    logic                    set_valid;
    logic                    wr_key;
    logic                    wr_value;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } upd_t;

endpackage

`default_nettype wire

// File: rtl/lrukv_cfg.sv
`default_nettype none

module lrukv_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lrukv_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lrukv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lrukv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                      pready,
  output logic      [lrukv_pkg::CAP_W-1:0]          cap_o
);

  logic [lrukv_pkg::CAP_W-1:0] cap_q;
  logic                        wr_en;

  // the only register sits at every address of the small window
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == paddr);

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrukv_pkg::CAP_RESET;
    end else if (wr_en) begin
      cap_q <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  // read back
  assign prdata = {{(lrukv_pkg::APB_DATA_W - lrukv_pkg::CAP_W){1'b0}}, cap_q};
  assign cap_o  = cap_q;

endmodule

`default_nettype wire

// File: rtl/lrukv_entry.sv
`default_nettype none

module lrukv_entry #(
  parameter int unsigned AgeW = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire lrukv_pkg::upd_t                        upd_i,
  input  wire logic                                   sel_i,
  input  wire logic [AgeW-1:0]                        age_limit_i,
  input  wire logic [AgeW-1:0]                        oldest_age_i,
  output logic                                        match_o,
  output logic                                        free_o,
  output logic                                        oldest_o,
  output logic      [AgeW-1:0]                        age_o,
  output logic signed [lrukv_pkg::VAL_W-1:0]          value_o
);

  logic                                valid_q;
  logic [AgeW-1:0]                     age_q;
  logic signed [lrukv_pkg::KEY_W-1:0]  key_q;
  logic signed [lrukv_pkg::VAL_W-1:0]  value_q;

  // lookup status
  assign match_o  = valid_q && (key_q == upd_i.key);
  assign free_o   = !valid_q;
  assign oldest_o = valid_q && (age_q == oldest_age_i);
  assign age_o    = age_q;
  assign value_o  = value_q;

  // valid bit and recency rank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (upd_i.en) begin
      if (sel_i) begin
        age_q <= '0;
        if (upd_i.set_valid) begin
          valid_q <= 1'b1;
        end
      end else if (valid_q && (age_q < age_limit_i)) begin
        age_q <= age_q + AgeW'(1);
      end
    end
  end

  // key and value storage
  always_ff @(posedge clk_i) begin
    if (upd_i.en && sel_i && upd_i.wr_key) begin
      key_q <= upd_i.key;
    end
    if (upd_i.en && sel_i && upd_i.wr_value) begin
      value_q <= upd_i.value;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Input channel (in_valid_i / in_ready_o / in_item_i): opcode get or put,
// key and value. Output channel (out_valid_o / out_ready_i / out_item_o):
// one result item per input item, in order: hit flag and read value
// (stored value on a get hit, all ones on a get miss, zero for a put).
// An item is taken into an input register, then compared against every
// entry at once and the store updated in one pass; the result lands in
// an output register. out_valid_o rises once the item has moved from the
// input register to the output register. Throughput is one item per cycle
// unless the receiver stalls, set by the all-entry compare and rank update.
// When the receiver stalls, the result holds in the output register and
// one more item can still enter the input register; after that in_ready_o
// drops until the output is taken.
// Reset clears all valid bits, ranks and the fill count, and sets the
// capacity register to 16. Capacity (APB, address 0) should only be
// written while no item is in flight.
module lru_key_value_cache #(
  parameter int unsigned MaxEntries = lrukv_pkg::MAX_ENTRIES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire lrukv_pkg::in_item_t                  in_item_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output lrukv_pkg::out_item_t                      out_item_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lrukv_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lrukv_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lrukv_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                      pready
);

  localparam int unsigned AgeW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > lrukv_pkg::CAP_W) ? CntW : lrukv_pkg::CAP_W;

  logic [lrukv_pkg::CAP_W-1:0] cap;

  // configuration register
  lrukv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  // input and output registers
  logic                 in_vld_q;
  lrukv_pkg::in_item_t  in_item_q;
  logic                 out_vld_q;
  lrukv_pkg::out_item_t out_item_q;
  logic                 advance;
  logic                 fire;
  logic [CntW-1:0]      used_q;

  assign advance     = !out_vld_q || out_ready_i;
  assign in_ready_o  = !in_vld_q || advance;
  assign fire        = in_vld_q && advance;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // entry array
  lrukv_pkg::upd_t                     upd;
  logic [MaxEntries-1:0]               sel;
  logic [AgeW-1:0]                     age_limit;
  logic [AgeW-1:0]                     oldest_age;
  logic [MaxEntries-1:0]               match_v;
  logic [MaxEntries-1:0]               free_v;
  logic [MaxEntries-1:0]               old_v;
  logic [AgeW-1:0]                     age_a [MaxEntries];
  logic signed [lrukv_pkg::VAL_W-1:0]  val_a [MaxEntries];

  for (genvar g = 0; g < MaxEntries; g++) begin : g_entry
    lrukv_entry #(
      .AgeW (AgeW)
    ) u_entry (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_i        (upd),
      .sel_i        (sel[g]),
      .age_limit_i  (age_limit),
      .oldest_age_i (oldest_age),
      .match_o      (match_v[g]),
      .free_o       (free_v[g]),
      .oldest_o     (old_v[g]),
      .age_o        (age_a[g]),
      .value_o      (val_a[g])
    );
  end

  // lowest-index pick of each candidate set
  logic [MaxEntries-1:0] found_oh;
  logic [MaxEntries-1:0] free_oh;
  logic [MaxEntries-1:0] old_oh;

  assign found_oh = match_v & (~match_v + MaxEntries'(1));
  assign free_oh  = free_v & (~free_v + MaxEntries'(1));
  assign old_oh   = old_v & (~old_v + MaxEntries'(1));

  // read rank and value of the hit entry
  logic [AgeW-1:0]                    hit_age;
  logic signed [lrukv_pkg::VAL_W-1:0] hit_val;

  always_comb begin
    hit_age = '0;
    hit_val = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (found_oh[i]) begin
        hit_age = hit_age | age_a[i];
        hit_val = hit_val | val_a[i];
      end
    end
  end

  // effective capacity, clamped to 1 .. MaxEntries
  logic [CmpW-1:0] cap_eff;
  logic [CmpW-1:0] cap_ext;
  logic            room;

  always_comb begin
    cap_ext = CmpW'(cap);
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(MaxEntries)) begin
      cap_eff = CmpW'(MaxEntries);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign room       = CmpW'(used_q) < cap_eff;
  assign oldest_age = AgeW'(used_q - CntW'(1));

  // decide the update and the result
  logic                 hit;
  logic                 is_put;
  logic                 do_insert;
  lrukv_pkg::out_item_t res;

  assign hit    = |match_v;
  assign is_put = (in_item_q.opcode == lrukv_pkg::OP_PUT);

  always_comb begin
    upd           = '0;
    upd.key       = in_item_q.key;
    upd.value     = in_item_q.value;
    sel           = '0;
    age_limit     = '0;
    do_insert     = 1'b0;
    res.hit       = hit;
    res.read_value = '0;
    if (hit) begin
      upd.en       = fire;
      upd.wr_value = is_put;
      sel          = found_oh;
      age_limit    = hit_age;
      if (!is_put) begin
        res.read_value = hit_val;
      end
    end else if (!is_put) begin
      res.read_value = lrukv_pkg::MISS_VALUE;
    end else if (room) begin
      do_insert     = fire && (|free_v);
      upd.en        = do_insert;
      upd.set_valid = 1'b1;
      upd.wr_key    = 1'b1;
      upd.wr_value  = 1'b1;
      sel           = free_oh;
      age_limit     = AgeW'(used_q);
    end else begin
      upd.en       = fire && (|old_v);
      upd.wr_key   = 1'b1;
      upd.wr_value = 1'b1;
      sel          = old_oh;
      age_limit    = oldest_age;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      used_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (do_insert) begin
        used_q <= used_q + CntW'(1);
      end
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lrukv_checker.sv
`default_nettype none

module lrukv_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_ready_o,
  input  wire logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  input  wire lrukv_pkg::out_item_t                 out_item_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lrukv_pkg::APB_DATA_W-1:0]     pwdata,
  input  wire logic [lrukv_pkg::APB_DATA_W-1:0]     prdata,
  input  wire logic                                 pready
);

  // input only stalls behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while output register empty");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // a miss reads all ones (get) or zero (put)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.hit |->
      (out_item_o.read_value == lrukv_pkg::MISS_VALUE) || (out_item_o.read_value == '0))
    else $error("miss returned a stored value");

  // capacity write is visible on read back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=>
      prdata == ($past(pwdata) & lrukv_pkg::APB_DATA_W'(5'h1f)))
    else $error("capacity read back mismatch");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lrukv_checker u_checker (.*);

`default_nettype wire

// File: tb/lru_key_value_cache_checker.sv
module lru_key_value_cache_checker
  import lrukv_pkg::*;
#(
  parameter int unsigned Entries = MAX_ENTRIES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_item_t              in_item_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_item_t             out_item_i,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic                  pready_i,
  input  wire logic [APB_DATA_W-1:0] pwdata_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                results_pending_o
);

  localparam int unsigned RANK_W = (Entries > 1) ? $clog2(Entries) : 1;

  // shadow copy of the store
  logic              live       [Entries];
  logic [KEY_W-1:0]  stored_key [Entries];
  logic [VAL_W-1:0]  stored_val [Entries];
  logic [RANK_W-1:0] rank       [Entries];
  logic [CAP_W-1:0]  fill_count;
  logic [CAP_W-1:0]  capacity;

  out_item_t   expected_results [$];
  int unsigned mismatches;

  // entry sel becomes rank 0, live entries younger than limit age by one
  function automatic void make_newest(int sel, int unsigned limit);
    for (int i = 0; i < Entries; i++) begin
      if (live[i] && i != sel && rank[i] < limit) begin
        rank[i] = rank[i] + 1'b1;
      end
    end
    rank[sel] = '0;
  endfunction

  // one get or put against the shadow store, returns the expected result
  function automatic out_item_t cache_access(in_item_t req);
    out_item_t   res;
    int          found;
    int          slot;
    int unsigned room;
    found = -1;
    slot  = -1;
    res.hit = 1'b0;
    res.read_value = '0;
    // zero capacity acts as one, anything above the entry count saturates
    if (capacity == 0) begin
      room = 1;
    end else if (capacity > Entries) begin
      room = Entries;
    end else begin
      room = capacity;
    end
    for (int i = 0; i < Entries; i++) begin
      if (found < 0 && live[i] && stored_key[i] == req.key) begin
        found = i;
      end
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (req.opcode == OP_GET) begin
        res.read_value = stored_val[found];
      end else begin
        stored_val[found] = req.value;
      end
      make_newest(found, rank[found]);
    end else if (req.opcode == OP_GET) begin
      res.read_value = MISS_VALUE;
    end else if (fill_count < room) begin
      // insert into the first free entry
      for (int i = 0; i < Entries; i++) begin
        if (slot < 0 && !live[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        make_newest(slot, 32'hFFFF_FFFF);
        live[slot]       = 1'b1;
        stored_key[slot] = req.key;
        stored_val[slot] = req.value;
        fill_count       = fill_count + 1'b1;
      end
    end else begin
      // full, or capacity lowered below the fill: replace the oldest entry
      for (int i = 0; i < Entries; i++) begin
        if (live[i] && (slot < 0 || rank[i] > rank[slot])) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        make_newest(slot, rank[slot]);
        stored_key[slot] = req.key;
        stored_val[slot] = req.value;
      end
    end
    return res;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        live[i]       = 1'b0;
        stored_key[i] = '0;
        stored_val[i] = '0;
        rank[i]       = '0;
      end
      fill_count = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
      expected_results.delete();
      mismatch_count_o  <= 0;
      results_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got hit %0b read_value %0d",
                   $time, out_item_i.hit, out_item_i.read_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_i.hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, got %0b",
                     $time, want.hit, out_item_i.hit);
            mismatches++;
          end
          if (out_item_i.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, want.read_value, out_item_i.read_value);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(cache_access(in_item_i));
      end
      // single register, so the address is not decoded
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        capacity = pwdata_i[CAP_W-1:0];
      end
      mismatch_count_o  <= mismatches;
      results_pending_o <= expected_results.size();
    end
  end

endmodule

// File: tb/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
  import lrukv_pkg::*;

  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned POOL_SIZE       = 24;
  localparam int unsigned HOLD_CYCLES     = 64;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = '0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned results_pending;

  // idle and stall odds in percent, set per phase
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // long receiver hold-off, requested by stimulus and timed by the receiver
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // small key pool so that gets and puts hit and entries get evicted
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      key_span = POOL_SIZE;

  // capacity and key spread per phase, the first phase runs at reset capacity
  int unsigned phase_cap  [NUM_PHASES] = '{16, 3, 0, 1, 31, 17, 2, 16, 8};
  int unsigned phase_span [NUM_PHASES] = '{24, 6, 3, 3, 24, 20, 5, 24, 12};

  lru_key_value_cache uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lru_key_value_cache_checker lru_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .results_pending_o(results_pending)
  );

  always #1 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item after random idle cycles, return once it is accepted
  task automatic send_item(input opcode_e op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item.opcode <= op;
    in_item.key <= key;
    in_item.value <= value;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    if ($urandom_range(99) < 75) begin
      key = key_pool[$urandom_range(key_span - 1)];
    end else begin
      key = $urandom;
    end
    send_item(opcode_e'($urandom_range(1)), key, $urandom);
  endtask

  // stop offering and wait until every expected result is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  // setup then access cycle, upper data bits are don't care
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    logic [APB_DATA_W-1:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {junk[APB_DATA_W-1:CAP_W], cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // stimulus
  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // miss on an empty store, extreme keys and values, update, miss value stored
    send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h5555_5555);
    send_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'h0000_0000, 32'hAAAA_AAAA);
    // fill all sixteen entries, then evict the oldest and look it up
    for (int k = 1; k <= 12; k++) begin
      send_item(OP_PUT, k, 32'h0101_0101 * k);
    end
    send_item(OP_PUT, 32'h0000_0064, 32'h0000_0064);
    send_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        write_capacity(CAP_W'(phase_cap[p]));
      end
      case (p % 4)
        0: begin
          idle_pct <= 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct <= 67;
          stall_pct <= 0;
        end
        2: begin
          idle_pct <= 0;
          stall_pct <= 67;
        end
        default: begin
          idle_pct <= 23;
          stall_pct <= 23;
        end
      endcase
      key_span = phase_span[p];
      // let the block fill up against a stalled receiver
      if (p == 0) begin
        hold_requests <= hold_requests + 1;
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[lru_key_value_cache] OK");
    end else begin
      $display("[lru_key_value_cache] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("[lru_key_value_cache] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lrukv_pkg.sv
rtl/lrukv_cfg.sv
rtl/lrukv_entry.sv
rtl/lru_key_value_cache.sv
rtl/lrukv_checker.sv
tb/lru_key_value_cache_checker.sv
tb/lru_key_value_cache_tb.sv
